// ===== sv/srl_pkg.sv =====
`default_nettype none
package srl_pkg;
    typedef enum logic [2:0] {
        VERDICT_ACCEPT  = 3'd0,
        VERDICT_BLOCKED = 3'd1,
        VERDICT_BAD_SIG = 3'd2,
        VERDICT_FAST    = 3'd3,
        VERDICT_BAD_CMD = 3'd4
    } verdict_t;

    localparam logic [2:0] REG_MIN_GAP   = 3'd0;
    localparam logic [2:0] REG_CALM_GAP  = 3'd1;
    localparam logic [2:0] REG_LIMIT     = 3'd2;
    localparam logic [2:0] REG_BLOCK_MS  = 3'd3;
    localparam logic [2:0] REG_IDLE_MS   = 3'd4;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] now_ms;
        logic        signature_ok;
        logic        command_ok;
    } pkt_t;

    typedef struct packed {
        logic [2:0] verdict;
        logic       near_limit;
        logic [4:0] violation_count;
        logic       table_full;
    } res_t;

    typedef struct packed {
        logic [15:0] min_gap_ms;
        logic [15:0] calm_gap_ms;
        logic [3:0]  violation_limit;
        logic [23:0] block_ms;
        logic [23:0] idle_ms;
    } cfg_t;
endpackage
`default_nettype wire

// ===== sv/srl_if.sv =====
`default_nettype none
interface pkt_if;
    logic        valid;
    logic        ready;
    logic [31:0] src_addr;
    logic [31:0] now_ms;
    logic        signature_ok;
    logic        command_ok;
    modport source (output valid, src_addr, now_ms, signature_ok, command_ok, input ready);
    modport sink (input valid, src_addr, now_ms, signature_ok, command_ok, output ready);
endinterface

interface res_if;
    logic       valid;
    logic       ready;
    logic [2:0] verdict;
    logic       near_limit;
    logic [4:0] violation_count;
    logic       table_full;
    modport source (output valid, verdict, near_limit, violation_count, table_full,
                    input ready);
    modport sink (input valid, verdict, near_limit, violation_count, table_full,
                  output ready);
endinterface

interface cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/srl_queue.sv =====
`default_nettype none
module srl_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire srl_pkg::pkt_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output srl_pkg::pkt_t      out_data
);
    import srl_pkg::*;

    pkt_t       mem_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg;
    logic       rp_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // store payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_data;
        end
    end

    // advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ===== sv/srl_engine.sv =====
`default_nettype none
module srl_engine #(
    parameter int BLOCK_ENTRIES = 16,
    parameter int RATE_ENTRIES  = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire srl_pkg::cfg_t cfg,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire srl_pkg::pkt_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output srl_pkg::res_t      out_data
);
    import srl_pkg::*;

    localparam int BW = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
    localparam int RW = (RATE_ENTRIES > 1) ? $clog2(RATE_ENTRIES) : 1;

    typedef enum logic [0:0] { ST_EXPIRE, ST_RUN } state_t;

    state_t      state_reg;
    logic [BLOCK_ENTRIES-1:0] bvalid_reg;
    logic [31:0] baddr_reg [BLOCK_ENTRIES];
    logic [31:0] bexp_reg  [BLOCK_ENTRIES];
    logic [RATE_ENTRIES-1:0] rvalid_reg;
    logic [31:0] raddr_reg [RATE_ENTRIES];
    logic [31:0] rlast_reg [RATE_ENTRIES];
    logic [4:0]  rviol_reg [RATE_ENTRIES];
    logic        ovalid_reg;
    res_t        odata_reg;

    logic        busy;
    logic        fire;
    logic [31:0] addr;
    logic [31:0] now;

    assign addr      = in_data.src_addr;
    assign now       = in_data.now_ms;
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign busy      = ovalid_reg && !out_ready;
    assign in_ready  = (state_reg == ST_RUN) && !busy;
    assign fire      = in_valid && in_ready;

    // per-entry matches
    logic [31:0]              bdiff [BLOCK_ENTRIES];
    logic [BLOCK_ENTRIES-1:0] bexpired;
    logic [BLOCK_ENTRIES-1:0] bmatch;
    logic [RATE_ENTRIES-1:0]  rmatch;
    logic [RATE_ENTRIES-1:0]  ridle;
    always_comb
    begin
        for (int i = 0; i < BLOCK_ENTRIES; i++)
        begin
            bdiff[i]    = now - bexp_reg[i];
            bexpired[i] = bvalid_reg[i] && !bdiff[i][31];
            bmatch[i]   = bvalid_reg[i] && (baddr_reg[i] == addr);
        end
        for (int i = 0; i < RATE_ENTRIES; i++)
        begin
            rmatch[i] = rvalid_reg[i] && (raddr_reg[i] == addr);
            ridle[i]  = rvalid_reg[i] && ((now - rlast_reg[i]) >= {8'd0, cfg.idle_ms});
        end
    end

    // lowest match and lowest free entries
    logic          rhit;
    logic [RW-1:0] ridx;
    logic          bfree_ok;
    logic [BW-1:0] bfree;
    logic          rfree_ok;
    logic [RW-1:0] rfree;
    always_comb
    begin
        rhit = 1'b0;
        ridx = '0;
        for (int i = RATE_ENTRIES - 1; i >= 0; i--)
        begin
            if (rmatch[i])
            begin
                rhit = 1'b1;
                ridx = RW'(i);
            end
        end
        bfree_ok = 1'b0;
        bfree    = '0;
        for (int i = BLOCK_ENTRIES - 1; i >= 0; i--)
        begin
            if (!bvalid_reg[i])
            begin
                bfree_ok = 1'b1;
                bfree    = BW'(i);
            end
        end
    end

    // rate validity after ageing, for new-entry search
    logic [RATE_ENTRIES-1:0] rkeep;
    always_comb
    begin
        for (int i = 0; i < RATE_ENTRIES; i++)
        begin
            rkeep[i] = rvalid_reg[i] && (rmatch[i] && (RW'(i) == ridx) || !ridle[i]);
        end
        rfree_ok = 1'b0;
        rfree    = '0;
        for (int i = RATE_ENTRIES - 1; i >= 0; i--)
        begin
            if (!rkeep[i])
            begin
                rfree_ok = 1'b1;
                rfree    = RW'(i);
            end
        end
    end

    // classify
    logic        blocked;
    logic        drop;
    logic [31:0] gap;
    logic [4:0]  hcount;
    logic [4:0]  inc;
    logic        viol;
    logic        calm;
    logic        too_fast;
    logic        need_block;
    res_t        res;
    always_comb
    begin
        blocked  = |bmatch;
        drop     = blocked || !in_data.signature_ok;
        gap      = now - rlast_reg[ridx];
        hcount   = rviol_reg[ridx];
        inc      = (hcount < 5'd31) ? hcount + 5'd1 : hcount;
        viol     = rhit && (gap <= {16'd0, cfg.min_gap_ms});
        calm     = rhit && !viol && (gap > {16'd0, cfg.calm_gap_ms});
        too_fast = viol && (inc > {1'b0, cfg.violation_limit});
        res.near_limit = 1'b0;
        res.table_full = 1'b0;
        if (drop)
        begin
            res.verdict         = blocked ? VERDICT_BLOCKED : VERDICT_BAD_SIG;
            res.violation_count = rhit ? hcount : 5'd0;
            need_block          = !blocked;
        end
        else
        begin
            res.verdict = too_fast ? VERDICT_FAST
                        : (!in_data.command_ok ? VERDICT_BAD_CMD : VERDICT_ACCEPT);
            res.violation_count = viol ? inc : ((calm || !rhit) ? 5'd0 : hcount);
            res.near_limit = viol && !too_fast;
            need_block = too_fast || !in_data.command_ok;
            if (!rhit && !rfree_ok) res.table_full = 1'b1;
        end
        if (need_block && !bfree_ok) res.table_full = 1'b1;
    end

    // rate validity after this item: aged, freed on too fast, or newly taken
    logic [RATE_ENTRIES-1:0] rvalid_next;
    always_comb
    begin
        rvalid_next = rkeep;
        if (rhit && too_fast)
        begin
            rvalid_next[ridx] = 1'b0;
        end
        else if (!rhit && rfree_ok)
        begin
            rvalid_next[rfree] = 1'b1;
        end
    end

    logic [BW-1:0] bf;
    assign bf = bfree;

    // sequence: free expired blocks, then process
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_EXPIRE;
            bvalid_reg <= '0;
            rvalid_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (fire) ovalid_reg <= 1'b1;
            else if (ovalid_reg && out_ready) ovalid_reg <= 1'b0;
            unique case (state_reg)
                ST_EXPIRE:
                begin
                    if (in_valid && !busy)
                    begin
                        bvalid_reg <= bvalid_reg & ~bexpired;
                        state_reg  <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (fire)
                    begin
                        state_reg  <= ST_EXPIRE;
                        odata_reg  <= res;
                        if (need_block && bfree_ok)
                        begin
                            bvalid_reg[bf] <= 1'b1;
                            baddr_reg[bf]  <= addr;
                            bexp_reg[bf]   <= now + {8'd0, cfg.block_ms};
                        end
                        if (!drop)
                        begin
                            rvalid_reg <= rvalid_next;
                            if (rhit)
                            begin
                                if (!too_fast)
                                begin
                                    rlast_reg[ridx] <= now;
                                end
                                if (viol) rviol_reg[ridx] <= inc;
                                else if (calm) rviol_reg[ridx] <= 5'd0;
                            end
                            else
                            begin
                                if (rfree_ok)
                                begin
                                    raddr_reg[rfree]  <= addr;
                                    rlast_reg[rfree]  <= now;
                                    rviol_reg[rfree]  <= 5'd0;
                                end
                            end
                        end
                    end
                end
                default: state_reg <= ST_EXPIRE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/source_rate_limiter_blocklist.sv =====
`default_nettype none
// Channel  Role    Payload
// pkt      sink    src_addr, now_ms, signature_ok, command_ok
// res      source  verdict, near_limit, violation_count, table_full
// cfg      sink    index (0..4), data
// Each item passes ST_EXPIRE, which frees expired blocklist entries, then
// ST_RUN, which searches and updates both register tables. A two-entry queue
// keeps accepting while the engine works, until full; the result register holds one item.
// Reset clears all valid bits and loads register defaults; no clearing pass.
module source_rate_limiter_blocklist #(
    parameter int BLOCK_ENTRIES = 16,
    parameter int RATE_ENTRIES  = 16
) (
    input wire logic clk,
    input wire logic rst_n,
    pkt_if.sink      pkt,
    res_if.source    res,
    cfg_if.sink      cfg
);
    import srl_pkg::*;

    cfg_t cfg_reg;
    pkt_t in_pkt;
    pkt_t q_pkt;
    logic q_valid;
    logic q_ready;
    res_t r;

    assign cfg.ready = 1'b1;

    // write registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_gap_ms      <= 16'd50;
            cfg_reg.calm_gap_ms     <= 16'd300;
            cfg_reg.violation_limit <= 4'd4;
            cfg_reg.block_ms        <= 24'd180000;
            cfg_reg.idle_ms         <= 24'd10000;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_MIN_GAP:  cfg_reg.min_gap_ms      <= cfg.data[15:0];
                REG_CALM_GAP: cfg_reg.calm_gap_ms     <= cfg.data[15:0];
                REG_LIMIT:    cfg_reg.violation_limit <= cfg.data[3:0];
                REG_BLOCK_MS: cfg_reg.block_ms        <= cfg.data;
                REG_IDLE_MS:  cfg_reg.idle_ms         <= cfg.data;
                default: ;
            endcase
        end
    end

    assign in_pkt.src_addr     = pkt.src_addr;
    assign in_pkt.now_ms       = pkt.now_ms;
    assign in_pkt.signature_ok = pkt.signature_ok;
    assign in_pkt.command_ok   = pkt.command_ok;

    srl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pkt.valid),
        .in_ready  (pkt.ready),
        .in_data   (in_pkt),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_pkt)
    );

    srl_engine #(
        .BLOCK_ENTRIES (BLOCK_ENTRIES),
        .RATE_ENTRIES  (RATE_ENTRIES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_data   (q_pkt),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_data  (r)
    );

    assign res.verdict         = r.verdict;
    assign res.near_limit      = r.near_limit;
    assign res.violation_count = r.violation_count;
    assign res.table_full      = r.table_full;
endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none
module tb_top;
    import srl_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pkt_if pkt ();
    res_if res ();
    cfg_if cfg ();

    source_rate_limiter_blocklist dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt),
        .res   (res),
        .cfg   (cfg)
    );

    always #5 clk = ~clk;

    // predictor state
    cfg_t        cur_cfg;
    logic        blk_v   [16];
    logic [31:0] blk_a   [16];
    logic [31:0] blk_exp [16];
    logic        rt_v    [16];
    logic [31:0] rt_a    [16];
    logic [31:0] rt_last [16];
    logic [4:0]  rt_cnt  [16];

    pkt_t pending_pkts [$];
    res_t expected_verdicts [$];
    int   fail_count = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic drv_busy = 1'b0;

    // shared address pool so sources repeat
    logic [31:0] addr_pool [8];

    // place a block entry at the lowest free slot; return 1 if none is free
    function automatic logic add_blocked(input logic [31:0] a, input logic [31:0] now);
        for (int i = 0; i < 16; i++)
        begin
            if (!blk_v[i])
            begin
                blk_v[i] = 1'b1;
                blk_a[i] = a;
                blk_exp[i] = now + {8'd0, cur_cfg.block_ms};
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic res_t predict_verdict(input pkt_t p);
        res_t r;
        logic blocked;
        int   hit;
        int   slot;
        logic [31:0] gap;
        logic [31:0] d;
        logic [4:0] c;
        logic too_fast;
        r = '0;
        blocked = 1'b0;
        hit = -1;
        slot = -1;
        too_fast = 1'b0;
        // drop expired blocks
        for (int i = 0; i < 16; i++)
        begin
            d = p.now_ms - blk_exp[i];
            if (blk_v[i] && !d[31])
                blk_v[i] = 1'b0;
        end
        for (int i = 0; i < 16; i++)
            if (blk_v[i] && blk_a[i] == p.src_addr)
                blocked = 1'b1;
        if (blocked || !p.signature_ok)
        begin
            for (int i = 0; i < 16; i++)
                if (hit < 0 && rt_v[i] && rt_a[i] == p.src_addr)
                    hit = i;
            if (hit >= 0)
                r.violation_count = rt_cnt[hit];
            if (blocked)
                r.verdict = VERDICT_BLOCKED;
            else
            begin
                r.verdict = VERDICT_BAD_SIG;
                r.table_full = add_blocked(p.src_addr, p.now_ms);
            end
        end
        else
        begin
            // find own entry, age out idle neighbours
            for (int i = 0; i < 16; i++)
            begin
                if (rt_v[i])
                begin
                    if (hit < 0 && rt_a[i] == p.src_addr)
                        hit = i;
                    else if (p.now_ms - rt_last[i] >= {8'd0, cur_cfg.idle_ms})
                        rt_v[i] = 1'b0;
                end
            end
            if (hit >= 0)
            begin
                gap = p.now_ms - rt_last[hit];
                if (gap <= {16'd0, cur_cfg.min_gap_ms})
                begin
                    c = rt_cnt[hit];
                    if (c < 5'd31)
                        c = c + 5'd1;
                    rt_cnt[hit] = c;
                    r.violation_count = c;
                    if (c > {1'b0, cur_cfg.violation_limit})
                    begin
                        too_fast = 1'b1;
                        if (add_blocked(p.src_addr, p.now_ms))
                            r.table_full = 1'b1;
                        rt_v[hit] = 1'b0;
                        r.verdict = VERDICT_FAST;
                    end
                    else
                        r.near_limit = 1'b1;
                end
                else if (gap > {16'd0, cur_cfg.calm_gap_ms})
                begin
                    rt_cnt[hit] = '0;
                    r.violation_count = '0;
                end
                else
                    r.violation_count = rt_cnt[hit];
                if (!too_fast)
                    rt_last[hit] = p.now_ms;
            end
            else
            begin
                for (int i = 0; i < 16; i++)
                    if (slot < 0 && !rt_v[i])
                        slot = i;
                if (slot >= 0)
                begin
                    rt_v[slot] = 1'b1;
                    rt_a[slot] = p.src_addr;
                    rt_last[slot] = p.now_ms;
                    rt_cnt[slot] = '0;
                end
                else
                    r.table_full = 1'b1;
                r.violation_count = '0;
            end
            if (r.verdict == VERDICT_ACCEPT && !p.command_ok)
            begin
                r.verdict = VERDICT_BAD_CMD;
                if (add_blocked(p.src_addr, p.now_ms))
                    r.table_full = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    // driver: present queued items, idle at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt.valid <= 1'b0;
            pkt.src_addr <= '0;
            pkt.now_ms <= '0;
            pkt.signature_ok <= 1'b0;
            pkt.command_ok <= 1'b0;
            drv_busy <= 1'b0;
        end
        else
        begin
            if (pkt.valid && pkt.ready)
                expected_verdicts.push_back(predict_verdict(
                    {pkt.src_addr, pkt.now_ms, pkt.signature_ok, pkt.command_ok}));
            if (!pkt.valid || pkt.ready)
            begin
                if (pending_pkts.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    pkt_t p;
                    p = pending_pkts.pop_front();
                    pkt.valid <= 1'b1;
                    pkt.src_addr <= p.src_addr;
                    pkt.now_ms <= p.now_ms;
                    pkt.signature_ok <= p.signature_ok;
                    pkt.command_ok <= p.command_ok;
                    drv_busy <= 1'b1;
                end
                else
                begin
                    pkt.valid <= 1'b0;
                    drv_busy <= 1'b0;
                end
            end
        end
    end

    // monitor: stall at random, check each item against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else
        begin
            if (res.valid && res.ready)
            begin
                if (expected_verdicts.size() == 0)
                    report_mismatch("unexpected item", 1, 0);
                else
                begin
                    res_t e;
                    e = expected_verdicts.pop_front();
                    if (res.verdict !== e.verdict)
                        report_mismatch("verdict", res.verdict, e.verdict);
                    if (res.near_limit !== e.near_limit)
                        report_mismatch("near_limit", res.near_limit, e.near_limit);
                    if (res.violation_count !== e.violation_count)
                        report_mismatch("violation_count", res.violation_count,
                                        e.violation_count);
                    if (res.table_full !== e.table_full)
                        report_mismatch("table_full", res.table_full, e.table_full);
                end
            end
            res.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // write one register and mirror it
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        case (idx)
            REG_MIN_GAP:  cur_cfg.min_gap_ms = val[15:0];
            REG_CALM_GAP: cur_cfg.calm_gap_ms = val[15:0];
            REG_LIMIT:    cur_cfg.violation_limit = val[3:0];
            REG_BLOCK_MS: cur_cfg.block_ms = val;
            REG_IDLE_MS:  cur_cfg.idle_ms = val;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [15:0] mg, input logic [15:0] cg,
                             input logic [3:0] lim, input logic [23:0] bm,
                             input logic [23:0] im);
        write_reg(REG_MIN_GAP, {8'd0, mg});
        write_reg(REG_CALM_GAP, {8'd0, cg});
        write_reg(REG_LIMIT, {20'd0, lim});
        write_reg(REG_BLOCK_MS, bm);
        write_reg(REG_IDLE_MS, im);
        cfg.valid <= 1'b0;
    endtask

    // hold until all queued items are sent and every result is back
    task automatic drain();
        @(posedge clk);
        while (pending_pkts.size() > 0 || drv_busy || pkt.valid
               || expected_verdicts.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic pkt_t mk(input logic [31:0] a, input logic [31:0] t,
                                input logic s, input logic c);
        pkt_t p;
        p.src_addr = a;
        p.now_ms = t;
        p.signature_ok = s;
        p.command_ok = c;
        return p;
    endfunction

    // burst sequences from a small pool of sources with mostly valid flags
    task automatic queue_random(input int n, input logic [31:0] t0);
        logic [31:0] t;
        t = t0;
        for (int k = 0; k < n; k++)
        begin
            case ($urandom_range(9))
                0: t = t + $urandom;
                1, 2: t = t + $urandom_range(400, 20000);
                default: t = t + $urandom_range(0, 80);
            endcase
            if ($urandom_range(9) == 0)
                pending_pkts.push_back(mk($urandom, t, 1'($urandom_range(1)),
                                          1'($urandom_range(1))));
            else
                pending_pkts.push_back(mk(addr_pool[3'($urandom_range(7))], t,
                                          $urandom_range(19) != 0, $urandom_range(14) != 0));
        end
    endtask

    initial
    begin
        cur_cfg.min_gap_ms = 16'd50;
        cur_cfg.calm_gap_ms = 16'd300;
        cur_cfg.violation_limit = 4'd4;
        cur_cfg.block_ms = 24'd180000;
        cur_cfg.idle_ms = 24'd10000;
        for (int i = 0; i < 16; i++)
        begin
            blk_v[i] = 1'b0;
            rt_v[i] = 1'b0;
        end
        for (int i = 0; i < 8; i++)
            addr_pool[i] = (i == 0) ? 32'hFFFF_FFFF : (i == 1) ? 32'd0 : $urandom;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        send_idle_pct = 38;
        recv_idle_pct = 88;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: defaults, bursts to a block, bad sig, bad cmd, wrap
        pending_pkts.push_back(mk(32'hFFFF_FFFF, 32'hFFFF_FFF0, 1'b1, 1'b1));
        for (int k = 0; k < 6; k++)
            pending_pkts.push_back(mk(32'hFFFF_FFFF, 32'hFFFF_FFF0 + k * 10, 1'b1, 1'b1));
        pending_pkts.push_back(mk(32'hFFFF_FFFF, 32'h100, 1'b1, 1'b1));
        pending_pkts.push_back(mk(32'd0, 32'h200, 1'b0, 1'b1));
        pending_pkts.push_back(mk(32'd0, 32'h300, 1'b1, 1'b1));
        pending_pkts.push_back(mk(32'd5, 32'h400, 1'b1, 1'b0));
        pending_pkts.push_back(mk(32'd6, 32'h500, 1'b1, 1'b1));
        pending_pkts.push_back(mk(32'd6, 32'h900, 1'b1, 1'b1));
        pending_pkts.push_back(mk(32'd6, 32'h901, 1'b1, 1'b1));
        // fill the rate table, then overflow it
        for (int k = 0; k < 18; k++)
            pending_pkts.push_back(mk(32'h1000 + k, 32'hA00, 1'b1, 1'b1));
        drain();

        // extremes: maximal minimum gap, zero calm gap, zero block and idle times; overlapping gap rule
        write_all(16'hFFFF, 16'd0, 4'd0, 24'd0, 24'd0);
        queue_random(200, $urandom);
        drain();

        // filling blocklist: long blocks, many bad sigs
        write_all(16'd100, 16'hFFFF, 4'd15, 24'hFFFFFF, 24'hFFFFFF);
        for (int k = 0; k < 20; k++)
            pending_pkts.push_back(mk($urandom, 32'd1000 + k, 1'b0, 1'b1));
        queue_random(150, 32'd2000);
        drain();

        send_idle_pct = 88;
        recv_idle_pct = 38;
        write_all(16'd0, 16'd40, 4'd2, 24'd500, 24'd300);
        queue_random(200, $urandom);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_all(16'd50, 16'd300, 4'd4, 24'd2000, 24'd10000);
        queue_random(250, $urandom);
        drain();
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("tb_top failed");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
sv/srl_pkg.sv
sv/srl_if.sv
sv/srl_queue.sv
sv/srl_engine.sv
sv/source_rate_limiter_blocklist.sv
bench/tb_top.sv
